[hw/rtl/sids_pkg.sv]
// Shared types and codes for the signed saturating divider.
package sids_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } sids_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } sids_state_t;

  typedef struct packed {
    logic load;    // capture operands, form magnitudes
    logic step;    // one restoring shift-subtract iteration
    logic finish;  // apply sign or saturation, fill output register
  } sids_cmd_t;

endpackage

[hw/rtl/sids_ctrl.sv]
// Sequencer for the divider: handshakes, iteration count, output valid.
module sids_ctrl #(
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sids_pkg::sids_cmd_t cmd
);

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  sids_pkg::sids_state_t state, state_next;
  logic [CW-1:0]         cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sids_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      sids_pkg::ST_IDLE: begin
        // refuse words while reset is held
        in_ready = ~rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          cnt_next   = CW'(DATA_WIDTH - 1);
          state_next = sids_pkg::ST_DIV;
        end
      end
      sids_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          state_next = sids_pkg::ST_DONE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      sids_pkg::ST_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = sids_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sids_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/sids_datapath.sv]
// Magnitude, restoring shift-subtract and sign fixup registers of the divider.
module sids_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  sids_pkg::sids_cmd_t   cmd,
  input  logic [DATA_WIDTH-1:0] numerator,
  input  logic [DATA_WIDTH-1:0] denominator,
  output logic [DATA_WIDTH-1:0] quotient,
  output sids_pkg::sids_status_t status
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0]           dvd;   // dividend bits shift out, quotient bits shift in
  logic [W-1:0]           rem;
  logic [W-1:0]           dmag;
  logic                   neg;
  sids_pkg::sids_status_t code;

  logic [W-1:0]           rem_shift;
  logic [W:0]             diff;
  logic [W-1:0]           n_mag;
  logic [W-1:0]           d_mag;
  logic [W-1:0]           min_val;
  logic [W-1:0]           q_signed;

  assign min_val = {1'b1, {(W-1){1'b0}}};

  // two's complement negation also maps the most negative value to 2^(W-1)
  assign n_mag = numerator[W-1]   ? (~numerator + 1'b1)   : numerator;
  assign d_mag = denominator[W-1] ? (~denominator + 1'b1) : denominator;

  assign rem_shift = {rem[W-2:0], dvd[W-1]};
  assign diff      = {1'b0, rem_shift} - {1'b0, dmag};
  assign q_signed  = neg ? (~dvd + 1'b1) : dvd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd  <= n_mag;
      dmag <= d_mag;
      rem  <= '0;
      neg  <= numerator[W-1] ^ denominator[W-1];
      if (denominator == '0) begin
        code <= sids_pkg::STATUS_DIV_ZERO;
      end else if (numerator == min_val && denominator == '1) begin
        code <= sids_pkg::STATUS_OVERFLOW;
      end else begin
        code <= sids_pkg::STATUS_OK;
      end
    end else if (cmd.step) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        dvd <= {dvd[W-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        dvd <= {dvd[W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      status <= code;
      if (code != sids_pkg::STATUS_OK) begin
        quotient <= {1'b0, {(W-1){1'b1}}};
      end else begin
        quotient <= q_signed;
      end
    end
  end

endmodule

[hw/rtl/signed_int_divider_saturating.sv]
// Top level of the signed saturating divider: sequencer plus datapath.
//
//  channel   | group       | payload
//  ----------+-------------+---------------------------------------------
//  input     | s_axis_*    | tdata: numerator, denominator (zero padded)
//  output    | m_axis_*    | tdata: quotient (zero padded); tuser: status
//
// The accepting edge loads the operands; each step of the shared
// shift-subtract unit then gives one quotient bit, and one more step applies
// the sign and fills the output register. A new word is taken in the cycle
// after the fixup, even while the previous result still waits in the output
// register. A stalled output holds the finished divider in its fixup step.
// Reset is synchronous, clears only the sequencer and the output valid, and
// holds the input ready low.
module signed_int_divider_saturating #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // numerator [DATA_WIDTH-1:0], denominator [2*DATA_WIDTH-1:DATA_WIDTH]
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // quotient [DATA_WIDTH-1:0]
  output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // status [1:0]
  output logic [1:0]                 m_axis_tuser
);

  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  sids_pkg::sids_cmd_t    cmd;
  sids_pkg::sids_status_t status;
  logic [DATA_WIDTH-1:0]  quotient;

  sids_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  sids_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .numerator   (s_axis_tdata[DATA_WIDTH-1:0]),
    .denominator (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .quotient    (quotient),
    .status      (status)
  );

  assign m_axis_tdata = OUT_W'(quotient);
  assign m_axis_tuser = status;

endmodule

[test/signed_int_divider_saturating_tb.sv]
// Testbench for the signed saturating divider: directed, random and backpressure runs.
`timescale 1ns / 1ps

module signed_int_divider_saturating_tb;

  localparam int DATA_WIDTH = 32;
  localparam int IN_BITS = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_BITS = ((DATA_WIDTH + 7) / 8) * 8;
  localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE = '1;
  localparam int DRAIN_CYCLES = 2 * (DATA_WIDTH + 2);
  localparam int CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [DATA_WIDTH-1:0]  quotient;
    sids_pkg::sids_status_t status;
  } division_result_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata;   // numerator, denominator
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_BITS-1:0] m_axis_tdata;   // quotient
  logic [1:0]          m_axis_tuser;   // status

  division_result_t expected_quotients[$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      hold_requests = 0;
  int unsigned      holds_seen = 0;
  int unsigned      hold_cycles_left = 0;

  signed_int_divider_saturating #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("signed_int_divider_saturating_tb NOT OK");
      $finish;
    end
  end

  // Restoring long division on magnitudes, then sign fixup; saturating cases first.
  function automatic division_result_t predict_division(logic [DATA_WIDTH-1:0] numerator,
                                                        logic [DATA_WIDTH-1:0] denominator);
    division_result_t      res;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic [DATA_WIDTH:0]   partial;
    logic [DATA_WIDTH-1:0] quo;
    if (denominator == '0) begin
      res.quotient = INT_MAX;
      res.status   = sids_pkg::STATUS_DIV_ZERO;
    end else if (numerator == INT_MIN && denominator == MINUS_ONE) begin
      res.quotient = INT_MAX;
      res.status   = sids_pkg::STATUS_OVERFLOW;
    end else begin
      // the most negative value negates to itself, which reads as its magnitude
      num_mag = numerator[DATA_WIDTH-1] ? ~numerator + 1'b1 : numerator;
      den_mag = denominator[DATA_WIDTH-1] ? ~denominator + 1'b1 : denominator;
      partial = '0;
      quo = '0;
      for (int b = DATA_WIDTH - 1; b >= 0; b--) begin
        partial = {partial[DATA_WIDTH-1:0], num_mag[b]};
        if (partial >= {1'b0, den_mag}) begin
          partial = partial - {1'b0, den_mag};
          quo[b] = 1'b1;
        end
      end
      if (numerator[DATA_WIDTH-1] != denominator[DATA_WIDTH-1]) quo = ~quo + 1'b1;
      res.quotient = quo;
      res.status   = sids_pkg::STATUS_OK;
    end
    return res;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] random_operand();
    logic [DATA_WIDTH-1:0] v;
    case ($urandom_range(7))
      0, 1, 2: v = $urandom;
      3: v = $urandom >> $urandom_range(DATA_WIDTH - 1);
      4: v = -($urandom >> $urandom_range(DATA_WIDTH - 1));
      5: begin
        v = $urandom_range(40);
        v = v - 20;
      end
      6: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 1;
          2: v = MINUS_ONE;
          3: v = INT_MIN;
          default: v = INT_MAX;
        endcase
      end
      default: v = $urandom >> 24;
    endcase
    return v;
  endfunction

  // Offer one word and hold it until accepted; the expectation is queued on acceptance.
  task automatic send_division(input logic [DATA_WIDTH-1:0] numerator,
                               input logic [DATA_WIDTH-1:0] denominator);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_BITS'({denominator, numerator});
    do @(posedge clk); while (!s_axis_tready);
    expected_quotients.push_back(predict_division(numerator, denominator));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_requests != holds_seen) begin
      holds_seen       <= hold_requests;
      hold_cycles_left <= HOLD_CYCLES;
      m_axis_tready    <= 1'b0;
    end else if (hold_cycles_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles_left <= hold_cycles_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    division_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_quotients.size() == 0) begin
        $error("unexpected result word: quotient %h status %0d", m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = expected_quotients.pop_front();
        if (m_axis_tdata[DATA_WIDTH-1:0] !== want.quotient) begin
          $error("quotient: expected %0d, actual %0d", $signed(want.quotient),
                 $signed(m_axis_tdata[DATA_WIDTH-1:0]));
          mismatch_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_division(7, 2);
    send_division(-7, 2);
    send_division(7, -2);
    send_division(-7, -2);
    send_division(0, 0);
    send_division(123, 0);
    send_division(INT_MIN, 0);
    send_division(INT_MAX, 0);
    send_division(INT_MIN, MINUS_ONE);
    send_division(INT_MIN, 1);
    send_division(INT_MAX, 1);
    send_division(INT_MAX, MINUS_ONE);
    send_division(INT_MIN, INT_MIN);
    send_division(INT_MAX, INT_MIN);
    send_division(INT_MIN, INT_MAX);
    send_division(INT_MAX, INT_MAX);
    send_division(0, 5);
    send_division(5, 7);
    send_division(1, INT_MAX);
    send_division(MINUS_ONE, 1);
    send_division(MINUS_ONE, MINUS_ONE);
    send_division(INT_MIN, 2);
    send_division(32'hFFFF_FFFE, 32'h8000_0001);
    wait_for_results();
  endtask

  task automatic test_random(input int count, input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_division(random_operand(), random_operand());
    wait_for_results();
  endtask

  // Stall the output long enough that the divider fills and refuses input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (12) send_division(random_operand(), random_operand());
    wait_for_results();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(400, 8, 69);
    test_random(400, 69, 8);
    test_random(400, 0, 0);
    test_backpressure();

    if (mismatch_count == 0) begin
      $display("signed_int_divider_saturating_tb OK");
    end else begin
      $display("signed_int_divider_saturating_tb NOT OK");
    end
    $finish;
  end

endmodule
